### rtl/core/swhc_pkg.sv
`timescale 1ns / 1ps

package swhc_pkg;

    // Number of stamp cells in the chain
    localparam int RING_DEPTH = 1024;

    localparam int STAMP_W      = 31;
    localparam int WINDOW_W     = 16;
    localparam int HIT_COUNT_W  = 11;
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);
    localparam int LIMIT_W      = STAMP_W + 1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(300);

    // Item kinds
    localparam logic ACT_HIT   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_RECHECK
    } swhc_state_t;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic               shift;
        logic               load;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } swhc_chain_ctl_t;

endpackage

### rtl/core/swhc_if.sv
`timescale 1ns / 1ps

interface swhc_req_if
    import swhc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [STAMP_W-1:0] timestamp;

    modport source (output valid, action, timestamp, input ready);
    modport sink   (input valid, action, timestamp, output ready);
endinterface

interface swhc_rsp_if
    import swhc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [HIT_COUNT_W-1:0] hit_count;
    logic                   dropped;

    modport source (output valid, hit_count, dropped, input ready);
    modport sink   (input valid, hit_count, dropped, output ready);
endinterface

interface swhc_cfg_if
    import swhc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] window_length;

    modport source (output valid, window_length, input ready);
    modport sink   (input valid, window_length, output ready);
endinterface

### rtl/core/swhc_cell.sv
`timescale 1ns / 1ps

module swhc_cell
    import swhc_pkg::*;
(
    input  logic               clk,
    input  logic               shift,
    input  logic               load,
    input  logic [STAMP_W-1:0] new_stamp,
    input  logic [STAMP_W-1:0] upstream_stamp,
    output logic [STAMP_W-1:0] stamp
);

    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;

    // Load a new hit, or take the neighbor's stamp as the row advances
    always_comb
    begin
        stamp_next = stamp_reg;
        if (load)
        begin
            stamp_next = new_stamp;
        end
        else if (shift)
        begin
            stamp_next = upstream_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign stamp = stamp_reg;

endmodule

### rtl/core/swhc_chain.sv
`timescale 1ns / 1ps

module swhc_chain
    import swhc_pkg::*;
(
    input  logic               clk,
    input  swhc_chain_ctl_t    ctl,
    output logic [STAMP_W-1:0] head_stamp
);

    logic [STAMP_W-1:0] stamp_w [RING_DEPTH];

    // Cell 0 holds the oldest hit; a new hit lands just past the youngest
    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_cell
        logic [STAMP_W-1:0] upstream;
        logic               load_here;

        if (i == RING_DEPTH - 1)
        begin : g_tail
            assign upstream = '0;
        end
        else
        begin : g_body
            assign upstream = stamp_w[i+1];
        end

        assign load_here = ctl.load && (ctl.count == CNT_W'(i));

        swhc_cell u_cell (
            .clk            (clk),
            .shift          (ctl.shift),
            .load           (load_here),
            .new_stamp      (ctl.stamp),
            .upstream_stamp (upstream),
            .stamp          (stamp_w[i])
        );
    end

    assign head_stamp = stamp_w[0];

endmodule

### rtl/core/swhc_ctrl.sv
`timescale 1ns / 1ps

module swhc_ctrl
    import swhc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    swhc_req_if.sink           req,
    swhc_rsp_if.source         rsp,
    swhc_cfg_if.sink           cfg,
    input  logic [STAMP_W-1:0] head_stamp,
    output swhc_chain_ctl_t    chain_ctl
);

    swhc_state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WINDOW_W-1:0]    window_reg;
    logic                   action_reg;
    logic [STAMP_W-1:0]     now_reg;
    logic                   drop_reg, drop_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HIT_COUNT_W-1:0] out_count_reg;
    logic                   out_drop_reg;

    logic [LIMIT_W-1:0] limit;
    logic               pop_ok;
    logic               full;
    logic               out_free;
    logic               req_fire;
    logic               do_shift;
    logic               do_push;
    logic               do_drop;
    logic               finish;
    logic [31:0]        count_ext;

    assign limit     = {1'b0, head_stamp} + LIMIT_W'(window_reg);
    assign pop_ok    = (count_reg != '0) && (limit <= {1'b0, now_reg});
    assign full      = (count_reg == CNT_W'(RING_DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign count_ext = 32'(count_next);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (!pop_ok)
                begin
                    if (action_reg == ACT_HIT)
                    begin
                        state_next = ST_RECHECK;
                    end
                    else if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RECHECK:
            begin
                if (!pop_ok && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        do_shift = 1'b0;
        do_push  = 1'b0;
        do_drop  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXPIRE:
            begin
                do_shift = pop_ok;
                if (!pop_ok)
                begin
                    if (action_reg == ACT_HIT)
                    begin
                        do_push = !full;
                        do_drop = full;
                    end
                    else
                    begin
                        finish = out_free;
                    end
                end
            end
            ST_RECHECK:
            begin
                do_shift = pop_ok;
                finish   = !pop_ok && out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        drop_next = drop_reg;
        if (req_fire)
        begin
            drop_next = 1'b0;
        end
        else if (do_drop)
        begin
            drop_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            window_reg    <= WINDOW_RESET;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                window_reg <= cfg.window_length;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            action_reg <= req.action;
            now_reg    <= req.timestamp;
        end
        if (finish)
        begin
            out_count_reg <= count_ext[HIT_COUNT_W-1:0];
            out_drop_reg  <= drop_reg;
        end
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit_count = out_count_reg;
    assign rsp.dropped   = out_drop_reg;

    assign chain_ctl.shift = do_shift;
    assign chain_ctl.load  = do_push;
    assign chain_ctl.count = count_reg;
    assign chain_ctl.stamp = now_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("live count beyond ring depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        do_shift |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not lower the live count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |-> !full && !do_shift)
        else $error("push into a full row or during a shift");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && drop_reg) |-> full && (action_reg == ACT_HIT))
        else $error("dropped flag without a full row");

    a_accept_expire: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == ST_EXPIRE && !drop_reg)
        else $error("accepted item did not start expiry");

endmodule

### rtl/core/sliding_window_hit_counter_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Carries                          Handshake
// -------  ---  -------------------------------  ------------------------
// req      in   action (1b), timestamp (31b)     valid/ready, one item
// rsp      out  hit_count (11b), dropped (1b)    valid/ready, one item
// cfg      in   window_length (16b)              valid/ready, ready high
//
// A query expires stale hits, then returns its count; a hit also pushes or
// drops, then expires again. Expiry retires one stored stamp per cycle from
// the row's head cell, so the cost of expiry is set by that single compare.
// rst_n clears the live count, the window (to 300) and the control state;
// the stamp cells keep no reset. A stalled rsp holds its item while the next
// req is taken; an item whose result cannot be placed waits in its last step.

module sliding_window_hit_counter_core
    import swhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    swhc_req_if.sink   req,
    swhc_rsp_if.source rsp,
    swhc_cfg_if.sink   cfg
);

    // Shift/load commands for the row and the oldest stored stamp back
    swhc_chain_ctl_t    chain_ctl;
    logic [STAMP_W-1:0] head_stamp;

    // Sequence each item: expire from the head; for a hit, push or drop, expire again
    swhc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .head_stamp (head_stamp),
        .chain_ctl  (chain_ctl)
    );

    // Hold the live stamps oldest first; advance the whole row on each pop
    swhc_chain u_chain (
        .clk        (clk),
        .ctl        (chain_ctl),
        .head_stamp (head_stamp)
    );

endmodule
